>>> sv/scma_pkg.sv
`default_nettype none

package scma_pkg;

	localparam int SYM_W   = 24;
	localparam int PLAIN_W = 48;
	localparam int ADD_W   = PLAIN_W + 1;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_GCD = 3'd4;
	localparam logic [2:0] KIND_LCM = 3'd5;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
	localparam logic [1:0] STATUS_GCD_ZERO = 2'd2;

	localparam logic [2:0] SYM_TO_VAL [8] = '{3'd0, 3'd1, 3'd4, 3'd2, 3'd5, 3'd7, 3'd6, 3'd3};
	localparam logic [2:0] VAL_TO_SYM [8] = '{3'd0, 3'd1, 3'd3, 3'd7, 3'd2, 3'd4, 3'd6, 3'd5};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

`default_nettype wire

>>> sv/scma_decode.sv
`default_nettype none

module scma_decode
	import scma_pkg::*;
#(
	parameter int DIGITS = 8
) (
	input  wire logic [SYM_W-1:0]    field,
	output logic      [3*DIGITS-1:0] value
);

	localparam int W  = 3 * DIGITS;
	localparam int FW = (W > SYM_W) ? W : SYM_W;

	logic [FW-1:0] field_x;

	assign field_x = FW'(field);

	always_comb begin
		value = '0;
		for (int i = 0; i < DIGITS; i++) begin
			value[3*i +: 3] = SYM_TO_VAL[field_x[3*i +: 3]];
		end
	end

endmodule

`default_nettype wire

>>> sv/symbol_coded_modular_alu_top.sv
// sequencing from input transfer to result: add, subtract, unused kinds and zero operands of divide, gcd
// and lcm go from load straight to done; multiply and divide make one bit-serial pass, gcd one division
// pass per euclid division, and lcm adds a division and a multiply pass; one shared 49-bit adder does every step
// flow: one item at a time, the next input transfer can come in the cycle after the output transfer
// reset: arst_n low clears the sequencer to idle with no result pending
`default_nettype none

module symbol_coded_modular_alu_top
	import scma_pkg::*;
#(
	parameter int DIGITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [SYM_W-1:0]   operand_a_symbols,
	input  wire logic [SYM_W-1:0]   operand_b_symbols,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [SYM_W-1:0]   result_symbols,
	output logic      [SYM_W-1:0]   remainder_symbols,
	output logic                    has_remainder,
	output logic      [PLAIN_W-1:0] plain_value,
	output logic      [1:0]         status
);

	localparam int W  = 3 * DIGITS;
	localparam int FW = (W > SYM_W) ? W : SYM_W;
	localparam int CW = $clog2(W);

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic lcm_phase_q;

	logic [2:0] kind_q;
	logic [W-1:0] a_q, b_q, num_q, den_q, pr_q;
	logic [PLAIN_W-1:0] mc_q, acc_q;
	logic [W-1:0] res_val_q, rmd_val_q;
	logic has_rem_q;
	logic [PLAIN_W-1:0] plain_q;
	logic [1:0] status_q;

	logic [W-1:0] a_dec, b_dec;
	logic [ADD_W-1:0] ax, ay;
	logic sub;
	logic [ADD_W:0] sum;
	logic [W:0] rprime;
	logic ge, last, a_zero, b_zero;
	logic [W-1:0] r_new, q_new;
	logic [PLAIN_W-1:0] acc_new;
	logic [FW-1:0] res_enc, rmd_enc;

	scma_decode #(.DIGITS(DIGITS)) u_dec_a (.field(operand_a_symbols), .value(a_dec));
	scma_decode #(.DIGITS(DIGITS)) u_dec_b (.field(operand_b_symbols), .value(b_dec));

	assign rprime = {pr_q, num_q[W-1]};

	// shared adder
	always_comb begin
		unique case (state_q)
			ST_LOAD: begin
				ax  = ADD_W'(a_q);
				ay  = ADD_W'(b_q);
				sub = (kind_q == KIND_SUB);
			end
			ST_DIV: begin
				ax  = ADD_W'(rprime);
				ay  = ADD_W'(den_q);
				sub = 1'b1;
			end
			ST_MUL: begin
				ax  = ADD_W'(acc_q);
				ay  = ADD_W'(mc_q);
				sub = 1'b0;
			end
			default: begin
				ax  = '0;
				ay  = '0;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, ax} + {1'b0, (sub ? ~ay : ay)} + (ADD_W + 1)'(sub);
	end

	assign ge      = sum[ADD_W];
	assign r_new   = ge ? sum[W-1:0] : rprime[W-1:0];
	assign q_new   = {num_q[W-2:0], ge};
	assign acc_new = num_q[0] ? sum[PLAIN_W-1:0] : acc_q;
	assign last    = (cnt_q == CW'(W - 1));
	assign a_zero  = (a_q == '0);
	assign b_zero  = (b_q == '0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lcm_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q       <= '0;
					lcm_phase_q <= 1'b0;
					priority if (kind_q == KIND_MUL) begin
						state_q <= ST_MUL;
					end else if (kind_q == KIND_DIV) begin
						state_q <= b_zero ? ST_DONE : ST_DIV;
					end else if (kind_q == KIND_GCD || kind_q == KIND_LCM) begin
						state_q <= (a_zero || b_zero) ? ST_DONE : ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						cnt_q <= '0;
						priority if (kind_q == KIND_DIV) begin
							state_q <= ST_DONE;
						end else if (lcm_phase_q) begin
							state_q <= ST_MUL;
						end else if (r_new == '0) begin
							if (kind_q == KIND_GCD) begin
								state_q <= ST_DONE;
							end else begin
								lcm_phase_q <= 1'b1;
							end
						end else begin
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q <= kind;
					a_q    <= a_dec;
					b_q    <= b_dec;
				end
			end
			ST_LOAD: begin
				res_val_q <= '0;
				rmd_val_q <= '0;
				has_rem_q <= 1'b0;
				plain_q   <= '0;
				status_q  <= STATUS_OK;
				num_q     <= a_q;
				den_q     <= b_q;
				pr_q      <= '0;
				mc_q      <= PLAIN_W'(a_q);
				acc_q     <= '0;
				priority if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
					res_val_q <= sum[W-1:0];
				end else if (kind_q == KIND_MUL) begin
					num_q <= b_q;
				end else if (kind_q == KIND_DIV) begin
					if (b_zero) begin
						status_q <= STATUS_DIV_ZERO;
					end
				end else if (kind_q == KIND_GCD) begin
					if (a_zero || b_zero) begin
						status_q <= STATUS_GCD_ZERO;
					end
				end else begin
				end
			end
			ST_DIV: begin
				num_q <= q_new;
				pr_q  <= r_new;
				if (last) begin
					priority if (kind_q == KIND_DIV) begin
						res_val_q <= q_new;
						rmd_val_q <= r_new;
						has_rem_q <= (r_new != '0);
					end else if (lcm_phase_q) begin
						mc_q  <= PLAIN_W'(b_q);
						acc_q <= '0;
					end else if (r_new == '0) begin
						if (kind_q == KIND_GCD) begin
							plain_q <= PLAIN_W'(den_q);
						end else begin
							num_q <= a_q;
							pr_q  <= '0;
						end
					end else begin
						num_q <= den_q;
						den_q <= r_new;
						pr_q  <= '0;
					end
				end
			end
			ST_MUL: begin
				acc_q <= acc_new;
				mc_q  <= mc_q << 1;
				num_q <= num_q >> 1;
				if (last) begin
					if (kind_q == KIND_MUL) begin
						res_val_q <= acc_new[W-1:0];
					end else begin
						plain_q <= acc_new;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// symbol encode of held results
	always_comb begin
		res_enc = '0;
		rmd_enc = '0;
		for (int i = 0; i < DIGITS; i++) begin
			res_enc[3*i +: 3] = VAL_TO_SYM[res_val_q[3*i +: 3]];
			rmd_enc[3*i +: 3] = VAL_TO_SYM[rmd_val_q[3*i +: 3]];
		end
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign out_valid         = (state_q == ST_DONE);
	assign result_symbols    = res_enc[SYM_W-1:0];
	assign remainder_symbols = rmd_enc[SYM_W-1:0];
	assign has_remainder     = has_rem_q;
	assign plain_value       = plain_q;
	assign status            = status_q;

endmodule

`default_nettype wire

>>> tb/symbol_coded_modular_alu_top_tb.sv
`timescale 1ns / 1ps

module symbol_coded_modular_alu_top_tb
	import scma_pkg::*;
();

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_ITEMS   = 150;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 1000;
	localparam logic [SYM_W-1:0] MAX_VALUE   = '1;
	localparam logic [SYM_W-1:0] MAX_SYMBOLS = 24'o55555555;
	localparam logic [SYM_W-1:0] FIB_HI      = 24'd9227465;
	localparam logic [SYM_W-1:0] FIB_LO      = 24'd5702887;

	typedef struct packed {
		logic [SYM_W-1:0]   result_symbols;
		logic [SYM_W-1:0]   remainder_symbols;
		logic               has_remainder;
		logic [PLAIN_W-1:0] plain_value;
		logic [1:0]         status;
	} alu_result_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [SYM_W-1:0] a_value;
		logic [SYM_W-1:0] b_value;
		logic             typed_in;
		alu_result_t      want;
	} alu_vector_t;

	localparam alu_result_t NO_RESULT = '0;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         kind = KIND_ADD;
	logic [SYM_W-1:0]   operand_a_symbols = '0;
	logic [SYM_W-1:0]   operand_b_symbols = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SYM_W-1:0]   result_symbols;
	logic [SYM_W-1:0]   remainder_symbols;
	logic               has_remainder;
	logic [PLAIN_W-1:0] plain_value;
	logic [1:0]         status;

	alu_result_t pending_results[$];
	int errors = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	logic [SYM_W-1:0] corner_symbols [4] = '{24'o0, 24'o1, MAX_SYMBOLS, 24'o55555554};

	alu_vector_t directed_vectors [25] = '{
		'{KIND_ADD, 24'd0, 24'd0, 1'b1, NO_RESULT},
		'{KIND_ADD, MAX_VALUE, 24'd1, 1'b1, NO_RESULT},
		'{KIND_ADD, MAX_VALUE, MAX_VALUE, 1'b0, NO_RESULT},
		'{KIND_SUB, 24'd0, 24'd1, 1'b1, '{MAX_SYMBOLS, 24'd0, 1'b0, 48'd0, STATUS_OK}},
		'{KIND_SUB, 24'd1, 24'd1, 1'b1, NO_RESULT},
		'{KIND_SUB, 24'o01234567, 24'o76543210, 1'b0, NO_RESULT},
		'{KIND_MUL, MAX_VALUE, MAX_VALUE, 1'b1, '{24'o1, 24'd0, 1'b0, 48'd0, STATUS_OK}},
		'{KIND_MUL, 24'o00010000, 24'o00010000, 1'b1, NO_RESULT},
		'{KIND_MUL, 24'o01234567, 24'o00000007, 1'b0, NO_RESULT},
		'{KIND_DIV, MAX_VALUE, 24'd0, 1'b1, '{24'd0, 24'd0, 1'b0, 48'd0, STATUS_DIV_ZERO}},
		'{KIND_DIV, 24'd0, 24'd0, 1'b1, '{24'd0, 24'd0, 1'b0, 48'd0, STATUS_DIV_ZERO}},
		'{KIND_DIV, MAX_VALUE, 24'd1, 1'b1, '{MAX_SYMBOLS, 24'd0, 1'b0, 48'd0, STATUS_OK}},
		'{KIND_DIV, 24'd1, MAX_VALUE, 1'b1, '{24'd0, 24'o1, 1'b1, 48'd0, STATUS_OK}},
		'{KIND_DIV, 24'o76543210, 24'o00000123, 1'b0, NO_RESULT},
		'{KIND_GCD, 24'd0, 24'd5, 1'b1, '{24'd0, 24'd0, 1'b0, 48'd0, STATUS_GCD_ZERO}},
		'{KIND_GCD, 24'd5, 24'd0, 1'b1, '{24'd0, 24'd0, 1'b0, 48'd0, STATUS_GCD_ZERO}},
		'{KIND_GCD, MAX_VALUE, MAX_VALUE, 1'b1, '{24'd0, 24'd0, 1'b0, 48'hFFFFFF, STATUS_OK}},
		'{KIND_GCD, FIB_HI, FIB_LO, 1'b0, NO_RESULT},
		'{KIND_GCD, 24'd12, 24'd18, 1'b0, NO_RESULT},
		'{KIND_LCM, 24'd0, MAX_VALUE, 1'b1, NO_RESULT},
		'{KIND_LCM, MAX_VALUE, 24'd0, 1'b1, NO_RESULT},
		'{KIND_LCM, FIB_HI, FIB_LO, 1'b0, NO_RESULT},
		'{KIND_LCM, MAX_VALUE, MAX_VALUE - 24'd1, 1'b0, NO_RESULT},
		'{KIND_SPARE_LO, MAX_VALUE, MAX_VALUE, 1'b1, NO_RESULT},
		'{KIND_SPARE_HI, 24'd1, 24'd1, 1'b1, NO_RESULT}
	};

	symbol_coded_modular_alu_top DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.operand_a_symbols (operand_a_symbols),
		.operand_b_symbols (operand_b_symbols),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_symbols    (result_symbols),
		.remainder_symbols (remainder_symbols),
		.has_remainder     (has_remainder),
		.plain_value       (plain_value),
		.status            (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [2:0] digit_of_symbol(input logic [2:0] code);
		case (code)
			3'd0: return 3'd0;
			3'd1: return 3'd1;
			3'd2: return 3'd4;
			3'd3: return 3'd2;
			3'd4: return 3'd5;
			3'd5: return 3'd7;
			3'd6: return 3'd6;
			default: return 3'd3;
		endcase
	endfunction

	function automatic logic [2:0] symbol_of_digit(input logic [2:0] digit);
		case (digit)
			3'd0: return 3'd0;
			3'd1: return 3'd1;
			3'd2: return 3'd3;
			3'd3: return 3'd7;
			3'd4: return 3'd2;
			3'd5: return 3'd4;
			3'd6: return 3'd6;
			default: return 3'd5;
		endcase
	endfunction

	function automatic logic [SYM_W-1:0] symbols_to_value(input logic [SYM_W-1:0] s);
		logic [SYM_W-1:0] v;
		v = '0;
		for (int i = 0; i < SYM_W / 3; i++)
			v[3*i +: 3] = digit_of_symbol(s[3*i +: 3]);
		return v;
	endfunction

	function automatic logic [SYM_W-1:0] value_to_symbols(input logic [SYM_W-1:0] v);
		logic [SYM_W-1:0] s;
		s = '0;
		for (int i = 0; i < SYM_W / 3; i++)
			s[3*i +: 3] = symbol_of_digit(v[3*i +: 3]);
		return s;
	endfunction

	function automatic logic [SYM_W-1:0] euclid_gcd(input logic [SYM_W-1:0] x,
			input logic [SYM_W-1:0] y);
		logic [SYM_W-1:0] t;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		return x;
	endfunction

	function automatic alu_result_t compute_alu(input logic [2:0] k,
			input logic [SYM_W-1:0] a_sym, input logic [SYM_W-1:0] b_sym);
		alu_result_t r;
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] b;
		logic [SYM_W-1:0] low;
		logic [PLAIN_W-1:0] wide_q;
		logic [PLAIN_W-1:0] wide_b;
		r = NO_RESULT;
		a = symbols_to_value(a_sym);
		b = symbols_to_value(b_sym);
		case (k)
			KIND_ADD: begin
				low = a + b;
				r.result_symbols = value_to_symbols(low);
			end
			KIND_SUB: begin
				low = a - b;
				r.result_symbols = value_to_symbols(low);
			end
			KIND_MUL: begin
				low = a * b;
				r.result_symbols = value_to_symbols(low);
			end
			KIND_DIV: begin
				if (b == 0) begin
					r.status = STATUS_DIV_ZERO;
				end else begin
					r.result_symbols = value_to_symbols(a / b);
					r.remainder_symbols = value_to_symbols(a % b);
					r.has_remainder = (a % b) != 0;
				end
			end
			KIND_GCD: begin
				if (a == 0 || b == 0)
					r.status = STATUS_GCD_ZERO;
				else
					r.plain_value = {{(PLAIN_W-SYM_W){1'b0}}, euclid_gcd(a, b)};
			end
			KIND_LCM: begin
				if (a != 0 && b != 0) begin
					wide_q = {{(PLAIN_W-SYM_W){1'b0}}, a / euclid_gcd(a, b)};
					wide_b = {{(PLAIN_W-SYM_W){1'b0}}, b};
					r.plain_value = wide_q * wide_b;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input logic [2:0] k, input logic [SYM_W-1:0] a_sym,
			input logic [SYM_W-1:0] b_sym, input logic typed_in, input alu_result_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand_a_symbols <= a_sym;
		operand_b_symbols <= b_sym;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_results.push_back(typed_in ? want : compute_alu(k, a_sym, b_sym));
	endtask

	initial begin
		logic [2:0] k;
		logic [SYM_W-1:0] a_sym;
		logic [SYM_W-1:0] b_sym;
		int g;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vectors[i])
			send_item(directed_vectors[i].kind, value_to_symbols(directed_vectors[i].a_value),
				value_to_symbols(directed_vectors[i].b_value), directed_vectors[i].typed_in,
				directed_vectors[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if ($urandom_range(0, 99) < 4)
				k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
			else
				k = 3'($urandom_range(KIND_ADD, KIND_LCM));
			a_sym = 24'($urandom);
			b_sym = 24'($urandom);
			case ($urandom_range(0, 9))
				5: begin
					a_sym = value_to_symbols(24'($urandom_range(0, 63)));
					b_sym = value_to_symbols(24'($urandom_range(0, 63)));
				end
				6: begin
					g = $urandom_range(1, 4095);
					a_sym = value_to_symbols(24'(g * $urandom_range(0, 4095)));
					b_sym = value_to_symbols(24'(g * $urandom_range(0, 4095)));
				end
				7: begin
					if ($urandom_range(0, 1))
						a_sym = '0;
					else
						b_sym = '0;
				end
				8: begin
					a_sym = corner_symbols[$urandom_range(0, 3)];
					b_sym = corner_symbols[$urandom_range(0, 3)];
				end
				9: b_sym = value_to_symbols(24'($urandom_range(1, 4095)));
				default: ;
			endcase
			send_item(k, a_sym, b_sym, 1'b0, NO_RESULT);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 16);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing pending");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result_symbols !== want.result_symbols) begin
						$error("result_symbols: expected %h, got %h",
							want.result_symbols, result_symbols);
						errors++;
					end
					if (remainder_symbols !== want.remainder_symbols) begin
						$error("remainder_symbols: expected %h, got %h",
							want.remainder_symbols, remainder_symbols);
						errors++;
					end
					if (has_remainder !== want.has_remainder) begin
						$error("has_remainder: expected %b, got %b",
							want.has_remainder, has_remainder);
						errors++;
					end
					if (plain_value !== want.plain_value) begin
						$error("plain_value: expected %h, got %h",
							want.plain_value, plain_value);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
				end
			end
			if ((out_valid === 1'b1 && out_stall === 1'b0) ||
					(in_valid && in_stall === 1'b0)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
